### src/lbpg_pkg.sv
package lbpg_pkg;

  localparam int NUM_LEDS_DEF       = 16;
  localparam int INTERVAL_WIDTH_DEF = 16;
  localparam int NUM_RATES          = 5;
  localparam int PATTERN_DEPTH      = 32;

  localparam int RATE_W    = 3;
  localparam int LED_IDX_W = 4;
  localparam int POS_W     = $clog2(PATTERN_DEPTH);
  localparam int LEN_W     = POS_W + 1;
  localparam int ITVL_W    = 11;

  typedef enum logic {
    FUNC_TICK   = 1'b0,
    FUNC_ASSIGN = 1'b1
  } func_t;

  typedef struct packed {
    logic fire;
    logic on;
  } gen_status_t;

  typedef struct packed {
    logic                 wr_en;
    logic [LED_IDX_W-1:0] led_index;
    logic [RATE_W-1:0]    rate;
  } led_cmd_t;

  function automatic logic [LEN_W-1:0] pat_len(input int rate);
    logic [LEN_W-1:0] len;
    case (rate)
      1:       len = LEN_W'(2);
      2:       len = LEN_W'(2);
      3:       len = LEN_W'(6);
      4:       len = LEN_W'(32);
      default: len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [ITVL_W-1:0] pat_interval(input logic [RATE_W-1:0] rate,
                                                     input logic [POS_W-1:0]  pos);
    logic [ITVL_W-1:0] itvl;
    case (rate)
      3'd1: itvl = ITVL_W'(1500);
      3'd2: itvl = ITVL_W'(250);
      3'd3: itvl = (pos == POS_W'(5)) ? ITVL_W'(1500) : ITVL_W'(500);
      3'd4: begin
        case (pos)
          POS_W'(1):  itvl = ITVL_W'(1000);
          POS_W'(3):  itvl = ITVL_W'(900);
          POS_W'(5):  itvl = ITVL_W'(800);
          POS_W'(7):  itvl = ITVL_W'(700);
          POS_W'(9):  itvl = ITVL_W'(600);
          POS_W'(11): itvl = ITVL_W'(500);
          POS_W'(13): itvl = ITVL_W'(400);
          POS_W'(15): itvl = ITVL_W'(300);
          POS_W'(17): itvl = ITVL_W'(200);
          default:    itvl = ITVL_W'(100);
        endcase
      end
      default: itvl = '0;
    endcase
    return itvl;
  endfunction

endpackage

### src/lbpg_rate_gen.sv
module lbpg_rate_gen import lbpg_pkg::*; #(
  parameter int INTERVAL_WIDTH = INTERVAL_WIDTH_DEF,
  parameter int RATE_ID        = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  output gen_status_t status
);

  localparam logic [LEN_W-1:0] Len = pat_len(RATE_ID);

  logic [POS_W-1:0]          pos;
  logic [POS_W-1:0]          pos_next;
  logic [INTERVAL_WIDTH-1:0] cnt;
  logic [INTERVAL_WIDTH-1:0] cnt_next;
  logic [LEN_W-1:0]          pos_eff;
  logic [LEN_W-1:0]          pos_inc;
  logic [INTERVAL_WIDTH-1:0] itvl;
  logic                      cnt_zero;
  logic                      active;

  assign active   = (Len != '0);
  assign cnt_zero = (cnt == '0);
  assign pos_eff  = ({1'b0, pos} >= Len) ? '0 : {1'b0, pos};
  assign pos_inc  = pos_eff + LEN_W'(1);
  assign pos_next = (pos_inc >= Len) ? '0 : pos_inc[POS_W-1:0];
  assign itvl     = INTERVAL_WIDTH'(pat_interval(RATE_W'(RATE_ID), pos_eff[POS_W-1:0]));

  always_comb begin
    if (!cnt_zero) begin
      cnt_next = cnt - INTERVAL_WIDTH'(1);
    end else if (itvl == '0) begin
      cnt_next = '0;
    end else begin
      cnt_next = itvl - INTERVAL_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      cnt <= '0;
    end else if (tick && active) begin
      cnt <= cnt_next;
      if (cnt_zero) begin
        pos <= pos_next;
      end
    end
  end

  assign status.fire = tick && active && cnt_zero;
  assign status.on   = !pos_eff[0];

endmodule

### src/lbpg_led_bank.sv
module lbpg_led_bank import lbpg_pkg::*; #(
  parameter int NUM_LEDS = NUM_LEDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  led_cmd_t                          cmd,
  input  gen_status_t [NUM_RATES-1:1]       gen,
  output logic        [NUM_LEDS-1:0]        level_next
);

  logic [RATE_W-1:0]   led_rate [NUM_LEDS];
  logic [NUM_LEDS-1:0] level;

  // each led follows the generator it is bound to, if that one fired
  always_comb begin
    level_next = level;
    for (int i = 0; i < NUM_LEDS; i++) begin
      for (int j = 1; j < NUM_RATES; j++) begin
        if (led_rate[i] == RATE_W'(j) && gen[j].fire) begin
          level_next[i] = gen[j].on;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        led_rate[i] <= '0;
      end
    end else begin
      level <= level_next;
      for (int i = 0; i < NUM_LEDS; i++) begin
        if (cmd.wr_en && (32'(cmd.led_index) == i)) begin
          led_rate[i] <= cmd.rate;
        end
      end
    end
  end

endmodule

### src/led_blink_pattern_generator_core.sv
// channel   direction  handshake                  payload
// item      in         item_valid / item_stall    func, led_index, rate_select
// result    out        result_valid / result_stall led_levels, fired_rates
//
// one item per cycle while item_stall is low; an item passes through the input register,
// then the result register after the rate generators and led update
// rst (synchronous) clears all led bindings, levels, counters and positions
// result_stall holds the result register; item_stall rises only while a
// captured item cannot move into a stalled result register
module led_blink_pattern_generator_core import lbpg_pkg::*; #(
  parameter int NUM_LEDS       = NUM_LEDS_DEF,
  parameter int INTERVAL_WIDTH = INTERVAL_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  func,
  input  logic [LED_IDX_W-1:0]  led_index,
  input  logic [RATE_W-1:0]     rate_select,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [NUM_LEDS-1:0]   led_levels,
  output logic [NUM_RATES-2:0]  fired_rates
);

  logic                 s1_valid;
  func_t                s1_func;
  logic [LED_IDX_W-1:0] s1_led_index;
  logic [RATE_W-1:0]    s1_rate;
  logic                 res_ready;
  logic                 proc;
  logic                 tick;
  led_cmd_t             cmd;
  logic [NUM_LEDS-1:0]  level_next;
  logic [NUM_RATES-2:0] fired_vec;

  gen_status_t [NUM_RATES-1:1] gen_st;

  assign res_ready  = !result_valid || !result_stall;
  assign proc       = s1_valid && res_ready;
  assign item_stall = s1_valid && !res_ready;
  assign tick       = proc && (s1_func == FUNC_TICK);

  always_comb begin
    cmd.wr_en     = proc && (s1_func == FUNC_ASSIGN) && (s1_rate < RATE_W'(NUM_RATES));
    cmd.led_index = s1_led_index;
    cmd.rate      = s1_rate;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (item_valid && !item_stall) || (s1_valid && !res_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_func      <= func_t'(func);
      s1_led_index <= led_index;
      s1_rate      <= rate_select;
    end
  end

  for (genvar g = 1; g < NUM_RATES; g++) begin : g_rate
    lbpg_rate_gen #(
      .INTERVAL_WIDTH (INTERVAL_WIDTH),
      .RATE_ID        (g)
    ) u_gen (
      .clk    (clk),
      .rst    (rst),
      .tick   (tick),
      .status (gen_st[g])
    );
    assign fired_vec[g-1] = gen_st[g].fire;
  end

  lbpg_led_bank #(
    .NUM_LEDS (NUM_LEDS)
  ) u_leds (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .gen        (gen_st),
    .level_next (level_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_ready) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_levels  <= '0;
      fired_rates <= '0;
    end else if (proc) begin
      led_levels  <= level_next;
      fired_rates <= fired_vec;
    end
  end

  a_assign_no_fire: assert property (@(posedge clk) disable iff (rst)
    (proc && (s1_func == FUNC_ASSIGN)) |=> (fired_rates == '0))
    else $error("generator fired on an assignment");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && result_valid))
    else $error("item stalled with free pipeline space");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !proc |=> ($stable(led_levels) && $stable(fired_rates)))
    else $error("result register changed without a transfer");

  a_assign_keeps_level: assert property (@(posedge clk) disable iff (rst)
    (proc && (s1_func == FUNC_ASSIGN)) |-> (level_next == led_levels) &&
    (fired_vec == '0))
    else $error("led levels moved on an assignment");

endmodule

### dv/tb_led_blink_pattern_generator_core.sv
`timescale 1ns / 1ps

module tb_led_blink_pattern_generator_core;
  import lbpg_pkg::*;

  localparam int LEDS           = NUM_LEDS_DEF;
  localparam int GENS           = NUM_RATES - 1;
  localparam int CNT_W          = INTERVAL_WIDTH_DEF;
  localparam int RANDOM_ITEMS   = 1850;
  localparam int IDLE_PCT       = 26;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RATE_MAX_CODE  = (1 << RATE_W) - 1;

  typedef enum logic [RATE_W-1:0] {
    RATE_HOLD   = 3'd0,
    RATE_SLOW   = 3'd1,
    RATE_FAST   = 3'd2,
    RATE_TRIPLE = 3'd3,
    RATE_PULSE  = 3'd4
  } blink_rate_e;

  typedef struct packed {
    logic [LEDS-1:0] levels;
    logic [GENS-1:0] fired;
  } led_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  logic                 func = FUNC_TICK;
  logic [LED_IDX_W-1:0] led_index = '0;
  logic [RATE_W-1:0]    rate_select = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [LEDS-1:0]      led_levels;
  logic [GENS-1:0]      fired_rates;

  // shadow state of the blink generators
  logic [RATE_W-1:0]    led_binding [LEDS];
  int unsigned          gen_position [NUM_RATES];
  logic [CNT_W-1:0]     ticks_left [NUM_RATES];
  logic [LEDS-1:0]      level_shadow;
  int unsigned          pattern_len [NUM_RATES] = '{0, 2, 2, 6, 32};

  led_result_t          expected_leds_q[$];
  logic                 gaps_on = 1'b1;
  int                   holdoff_requests = 0;
  int                   holdoff_served = 0;
  int                   hold_left = 0;
  int                   idle_cycles = 0;
  int                   items_sent = 0;
  int                   results_checked = 0;
  int                   mismatches = 0;
  int                   ticks_seen = 0;
  int                   assigns_seen = 0;
  int                   ignored_assigns = 0;
  int                   fires_seen [GENS] = '{0, 0, 0, 0};

  led_blink_pattern_generator_core DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .led_index    (led_index),
    .rate_select  (rate_select),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .led_levels   (led_levels),
    .fired_rates  (fired_rates)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int unsigned interval_ticks(int unsigned rate, int unsigned pos);
    int unsigned ticks;
    ticks = 0;
    case (rate)
      RATE_SLOW:   ticks = 1500;
      RATE_FAST:   ticks = 250;
      RATE_TRIPLE: ticks = (pos == 5) ? 1500 : 500;
      RATE_PULSE: begin
        // odd slots count down from 1000 by 100 until they reach 100
        if (pos[0] && pos < 19) ticks = 1000 - 100 * (pos - 1) / 2;
        else ticks = 100;
      end
      default:     ticks = 0;
    endcase
    return ticks;
  endfunction

  function automatic led_result_t predict_leds(logic f, logic [LED_IDX_W-1:0] idx,
                                               logic [RATE_W-1:0] rsel);
    led_result_t res;
    int unsigned pos;
    int unsigned itvl;
    res.fired = '0;
    if (f == FUNC_TICK) begin
      for (int r = 1; r < NUM_RATES; r++) begin
        if (pattern_len[r] != 0) begin
          if (ticks_left[r] != '0) begin
            ticks_left[r] = ticks_left[r] - 1'b1;
          end else begin
            pos = gen_position[r];
            if (pos >= pattern_len[r]) pos = 0;
            itvl = interval_ticks(r, pos) & ((1 << CNT_W) - 1);
            ticks_left[r] = (itvl == 0) ? '0 : CNT_W'(itvl - 1);
            for (int i = 0; i < LEDS; i++) begin
              if (led_binding[i] == r) level_shadow[i] = ~pos[0];
            end
            pos++;
            if (pos >= pattern_len[r]) pos = 0;
            gen_position[r] = pos;
            res.fired[r-1] = 1'b1;
          end
        end
      end
    end else if (rsel < NUM_RATES && idx < LEDS) begin
      led_binding[idx] = rsel;
    end
    res.levels = level_shadow;
    return res;
  endfunction

  // transfer monitor and result checker
  always @(posedge clk) begin
    led_result_t exp_res;
    led_result_t got;
    if (!rst && result_valid && !result_stall) begin
      results_checked++;
      if (expected_leds_q.size() == 0) begin
        $error("result transfer with no expected result pending");
        mismatches++;
      end else begin
        exp_res = expected_leds_q.pop_front();
        if (led_levels !== exp_res.levels) begin
          $error("led_levels: expected %h, actual %h", exp_res.levels, led_levels);
          mismatches++;
        end
        if (fired_rates !== exp_res.fired) begin
          $error("fired_rates: expected %h, actual %h", exp_res.fired, fired_rates);
          mismatches++;
        end
      end
    end
    if (!rst && item_valid && !item_stall) begin
      got = predict_leds(func, led_index, rate_select);
      expected_leds_q.push_back(got);
      if (func == FUNC_TICK) begin
        ticks_seen++;
        for (int g = 0; g < GENS; g++) fires_seen[g] += got.fired[g];
      end else begin
        assigns_seen++;
        if (rate_select >= NUM_RATES) ignored_assigns++;
      end
    end
  end

  // receiver: random stalls plus a requested long hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holdoff_served != holdoff_requests) begin
      holdoff_served <= holdoff_requests;
      hold_left <= HOLDOFF_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(logic f, logic [LED_IDX_W-1:0] idx, logic [RATE_W-1:0] rsel);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid  <= 1'b1;
    func        <= f;
    led_index   <= idx;
    rate_select <= rsel;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_for_results();
    item_valid <= 1'b0;
    while (results_checked < items_sent) @(posedge clk);
  endtask

  task automatic test_reset_tick_and_assign();
    // first tick after reset fires every generator with all leds unbound
    send_item(FUNC_TICK, '0, '0);
    send_item(FUNC_ASSIGN, 4'd0, RATE_SLOW);
    send_item(FUNC_ASSIGN, 4'd15, RATE_FAST);
    send_item(FUNC_ASSIGN, 4'd7, RATE_PULSE);
    send_item(FUNC_ASSIGN, 4'd8, RATE_TRIPLE);
    send_item(FUNC_ASSIGN, 4'd5, RATE_HOLD);
    send_item(FUNC_TICK, '1, '1);
    send_item(FUNC_TICK, '0, '0);
    // rebinding moves the led off its old rate
    send_item(FUNC_ASSIGN, 4'd0, RATE_FAST);
    send_item(FUNC_TICK, 4'd0, RATE_SLOW);
    wait_for_results();
  endtask

  task automatic test_out_of_range_assign();
    send_item(FUNC_ASSIGN, 4'd3, RATE_W'(NUM_RATES));
    send_item(FUNC_ASSIGN, 4'd3, RATE_W'(RATE_MAX_CODE));
    send_item(FUNC_ASSIGN, 4'd12, RATE_W'(6));
    send_item(FUNC_ASSIGN, 4'd15, RATE_HOLD);
    send_item(FUNC_TICK, 4'd3, RATE_W'(RATE_MAX_CODE));
    wait_for_results();
  endtask

  task automatic test_result_holdoff();
    gaps_on <= 1'b0;
    holdoff_requests <= holdoff_requests + 1;
    for (int n = 0; n < 40; n++) begin
      send_item(FUNC_TICK, LED_IDX_W'($urandom), RATE_W'($urandom));
    end
    gaps_on <= 1'b1;
    wait_for_results();
  endtask

  task automatic test_random_mix();
    logic [RATE_W-1:0] rsel;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on <= !(n >= 700 && n < 1100);
      if ($urandom_range(99) < 85) begin
        send_item(FUNC_TICK, LED_IDX_W'($urandom), RATE_W'($urandom));
      end else begin
        if ($urandom_range(9) < 8) rsel = RATE_W'($urandom_range(NUM_RATES - 1));
        else rsel = RATE_W'($urandom_range(RATE_MAX_CODE, NUM_RATES));
        send_item(FUNC_ASSIGN, LED_IDX_W'($urandom), rsel);
      end
    end
    gaps_on <= 1'b1;
    wait_for_results();
  endtask

  initial begin
    for (int i = 0; i < LEDS; i++) led_binding[i] = RATE_HOLD;
    for (int r = 0; r < NUM_RATES; r++) begin
      gen_position[r] = 0;
      ticks_left[r] = '0;
    end
    level_shadow = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_tick_and_assign();
    test_out_of_range_assign();
    test_result_holdoff();
    test_random_mix();
    repeat (8) @(posedge clk);
    if (expected_leds_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_leds_q.size());
      mismatches++;
    end
    $display("covered %0d transfers: %0d ticks, %0d assignments (%0d out of range)",
             items_sent, ticks_seen, assigns_seen, ignored_assigns);
    $display("fires per rate slow/fast/triple/pulse: %0d/%0d/%0d/%0d, %0d checked",
             fires_seen[0], fires_seen[1], fires_seen[2], fires_seen[3], results_checked);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### led_blink_pattern_generator_core.f
src/lbpg_pkg.sv
src/lbpg_rate_gen.sv
src/lbpg_led_bank.sv
src/led_blink_pattern_generator_core.sv
dv/tb_led_blink_pattern_generator_core.sv
